// ===== rtl/pdfm_pkg.sv =====
// Package with the types and constants shared by the PWM duty and frequency meter.
package pdfm_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int TICK_W = 24;
  localparam int DUTY_W = 7;
  localparam int FREQ_W = 16;
  localparam int DUTY_ITER = 7;
  localparam int FREQ_ITER = 24;
  localparam int ITER_W = 5;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 72;
  localparam logic [TICK_W-1:0] TICK_RATE_RESET = 24'd7812;
  localparam logic [FREQ_W-1:0] FREQ_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DUTY,
    ST_FREQ,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/pwm_duty_frequency_meter.sv =====
// Top level of the PWM duty and frequency meter with its shared restoring divider.
//
// One item on the s_axis channel is one sampled PWM level, taken once per timer tick.
// The block waits for the first rising edge, then counts ticks between edges; a
// falling edge captures the high time and a rising edge the low time. Once both
// times are held, every edge yields one item on m_axis: duty percent, frequency in
// hertz (saturating at 65535), and the two captured tick counts.
// The cfg channel writes tick_rate, the number of ticks per second; it is always
// ready. The user must write it only while the block is idle; the block does not
// enforce this. An item that yields no result leaves s_axis_tready high. An item
// that yields a result keeps s_axis_tready low while the block forms the period and
// the scaled high time, runs 7 divider steps for the duty and 24 for the frequency
// on its single subtract-and-compare unit, and loads the output register. When the
// receiver stalls, the result holds in the output register and the block waits
// after the division until that register is free.
// Synchronous reset clears the captures and the tick count and sets tick_rate to 7812.
module pwm_duty_frequency_meter #(
  parameter int COUNT_WIDTH = pdfm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [pdfm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // pwm_level, zero fill
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // duty_percent, frequency_hz, high_ticks, low_ticks, zero fill
  output logic [pdfm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pdfm_pkg::TICK_W-1:0]        cfg_data
);

  localparam int PW = COUNT_WIDTH + 1;
  localparam int RW = COUNT_WIDTH + 2;
  localparam int MW = COUNT_WIDTH + 7;
  localparam int DW = pdfm_pkg::TICK_W;

  pdfm_pkg::state_t state, state_next;

  logic [pdfm_pkg::TICK_W-1:0] tick_rate;
  logic [COUNT_WIDTH-1:0] elapsed_ticks;
  logic [COUNT_WIDTH-1:0] high_capture;
  logic [COUNT_WIDTH-1:0] low_capture;
  logic                   last_level;
  logic                   started;
  logic [1:0]             both_captured;

  logic [PW-1:0]             period;
  logic [RW-1:0]             rem;
  logic [DW-1:0]             dvd;
  logic [DW-1:0]             quo;
  logic [pdfm_pkg::ITER_W-1:0] cnt;
  logic [pdfm_pkg::DUTY_W-1:0] duty;

  logic                   accept;
  logic                   level;
  logic                   rising;
  logic                   falling;
  logic [COUNT_WIDTH-1:0] elapsed_inc;
  logic [1:0]             captured_next;
  logic                   result_due;
  logic [MW-1:0]          high_ext;
  logic [MW-1:0]          scaled_high;
  logic [RW-1:0]          rem_shift;
  logic [RW-1:0]          rem_diff;
  logic                   fits;
  logic                   out_free;
  logic [pdfm_pkg::FREQ_W-1:0] freq_sat;

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign level       = s_axis_tdata[0];
  assign rising      = level && !last_level;
  assign falling     = !level && last_level;
  assign elapsed_inc = (elapsed_ticks == '1) ? elapsed_ticks : elapsed_ticks + 1'b1;
  assign captured_next = both_captured | {rising, falling};
  assign result_due  = started && (rising || falling) && (captured_next == 2'b11);

  assign high_ext    = MW'(high_capture);
  assign scaled_high = (high_ext << 6) + (high_ext << 5) + (high_ext << 2);

  assign rem_shift = {rem[RW-2:0], dvd[DW-1]};
  assign rem_diff  = rem_shift - RW'(period);
  assign fits      = rem_shift >= RW'(period);

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign freq_sat  = (quo > DW'(pdfm_pkg::FREQ_MAX)) ? pdfm_pkg::FREQ_MAX
                                                     : quo[pdfm_pkg::FREQ_W-1:0];
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      pdfm_pkg::ST_IDLE: if (accept && result_due) state_next = pdfm_pkg::ST_PREP;
      pdfm_pkg::ST_PREP: state_next = pdfm_pkg::ST_DUTY;
      pdfm_pkg::ST_DUTY: if (cnt == '0) state_next = pdfm_pkg::ST_FREQ;
      pdfm_pkg::ST_FREQ: if (cnt == '0) state_next = pdfm_pkg::ST_DONE;
      pdfm_pkg::ST_DONE: if (out_free) state_next = pdfm_pkg::ST_IDLE;
      default: state_next = pdfm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == pdfm_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdfm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate <= pdfm_pkg::TICK_RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tick_rate <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ticks <= '0;
      high_capture  <= '0;
      low_capture   <= '0;
      last_level    <= 1'b0;
      started       <= 1'b0;
      both_captured <= 2'b00;
    end else if (accept) begin
      last_level <= level;
      if (!started) begin
        if (rising) begin
          started       <= 1'b1;
          elapsed_ticks <= '0;
        end
      end else if (rising || falling) begin
        elapsed_ticks <= '0;
        both_captured <= captured_next;
        if (falling) begin
          high_capture <= elapsed_inc;
        end else begin
          low_capture <= elapsed_inc;
        end
      end else begin
        elapsed_ticks <= elapsed_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      pdfm_pkg::ST_PREP: begin
        period <= PW'(high_capture) + PW'(low_capture);
        rem    <= RW'(scaled_high[MW-1:pdfm_pkg::DUTY_W]);
        dvd    <= {scaled_high[pdfm_pkg::DUTY_W-1:0], (DW-pdfm_pkg::DUTY_W)'(0)};
        quo    <= '0;
        cnt    <= pdfm_pkg::ITER_W'(pdfm_pkg::DUTY_ITER - 1);
      end
      pdfm_pkg::ST_DUTY: begin
        if (cnt == '0) begin
          duty <= {quo[pdfm_pkg::DUTY_W-2:0], fits};
          rem  <= '0;
          dvd  <= tick_rate;
          quo  <= '0;
          cnt  <= pdfm_pkg::ITER_W'(pdfm_pkg::FREQ_ITER - 1);
        end else begin
          rem <= fits ? rem_diff : rem_shift;
          dvd <= dvd << 1;
          quo <= {quo[DW-2:0], fits};
          cnt <= cnt - 1'b1;
        end
      end
      pdfm_pkg::ST_FREQ: begin
        rem <= fits ? rem_diff : rem_shift;
        dvd <= dvd << 1;
        quo <= {quo[DW-2:0], fits};
        if (cnt != '0) begin
          cnt <= cnt - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == pdfm_pkg::ST_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pdfm_pkg::ST_DONE && out_free) begin
      m_axis_tdata <= {1'b0,
                       pdfm_pkg::TICK_W'(low_capture),
                       pdfm_pkg::TICK_W'(high_capture),
                       freq_sat,
                       duty};
    end
  end

endmodule

// ===== verif/pwm_duty_frequency_meter_test.sv =====
// Self-checking testbench for the PWM duty and frequency meter, with its scoreboard.
`timescale 1ns / 1ps

module pwm_duty_frequency_meter_test;

  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASE_ITEMS = 360;

  typedef struct packed {
    logic [pdfm_pkg::DUTY_W-1:0] duty;
    logic [pdfm_pkg::FREQ_W-1:0] freq;
    logic [pdfm_pkg::TICK_W-1:0] high_t;
    logic [pdfm_pkg::TICK_W-1:0] low_t;
  } reading_t;

  class duty_freq_tracker;
    logic [pdfm_pkg::TICK_W-1:0] rate;
    logic [pdfm_pkg::COUNT_WIDTH_DEF-1:0] elapsed;
    logic [pdfm_pkg::COUNT_WIDTH_DEF-1:0] high_cap;
    logic [pdfm_pkg::COUNT_WIDTH_DEF-1:0] low_cap;
    bit prev_level;
    bit running;
    bit have_high;
    bit have_low;
    reading_t readings[$];
    int errors;

    function new();
      rate = pdfm_pkg::TICK_RATE_RESET;
      elapsed = '0;
      high_cap = '0;
      low_cap = '0;
      prev_level = 1'b0;
      running = 1'b0;
      have_high = 1'b0;
      have_low = 1'b0;
      errors = 0;
    endfunction

    function void set_rate(logic [pdfm_pkg::TICK_W-1:0] value);
      rate = value;
    endfunction

    function int pending();
      return readings.size();
    endfunction

    function void note_sample(bit lvl);
      bit rise;
      bit fall;
      longint unsigned period;
      longint unsigned duty;
      longint unsigned freq;
      reading_t r;
      rise = lvl && !prev_level;
      fall = !lvl && prev_level;
      prev_level = lvl;
      if (!running) begin
        if (rise) begin
          running = 1'b1;
          elapsed = '0;
        end
        return;
      end
      if (elapsed != '1) elapsed = elapsed + 1'b1;
      if (!rise && !fall) return;
      if (fall) begin
        high_cap = elapsed;
        have_high = 1'b1;
      end else begin
        low_cap = elapsed;
        have_low = 1'b1;
      end
      elapsed = '0;
      if (have_high && have_low) begin
        period = 64'(high_cap) + 64'(low_cap);
        duty = 0;
        freq = 0;
        if (period != 0) begin
          duty = (100 * 64'(high_cap)) / period;
          freq = 64'(rate) / period;
        end
        if (freq > 64'(pdfm_pkg::FREQ_MAX)) freq = 64'(pdfm_pkg::FREQ_MAX);
        r.duty = pdfm_pkg::DUTY_W'(duty);
        r.freq = pdfm_pkg::FREQ_W'(freq);
        r.high_t = pdfm_pkg::TICK_W'(high_cap);
        r.low_t = pdfm_pkg::TICK_W'(low_cap);
        readings.push_back(r);
      end
    endfunction

    function void check_reading(logic [pdfm_pkg::OUT_TDATA_W-1:0] data);
      reading_t want;
      reading_t got;
      got.duty = data[pdfm_pkg::DUTY_W-1:0];
      got.freq = data[pdfm_pkg::DUTY_W +: pdfm_pkg::FREQ_W];
      got.high_t = data[pdfm_pkg::DUTY_W+pdfm_pkg::FREQ_W +: pdfm_pkg::TICK_W];
      got.low_t = data[pdfm_pkg::DUTY_W+pdfm_pkg::FREQ_W+pdfm_pkg::TICK_W +: pdfm_pkg::TICK_W];
      if (readings.size() == 0) begin
        $display("%0t: unexpected result, tdata %h", $time, data);
        errors++;
        return;
      end
      want = readings.pop_front();
      if (got.duty !== want.duty) begin
        $display("%0t: duty_percent expected %0d actual %0d", $time, want.duty, got.duty);
        errors++;
      end
      if (got.freq !== want.freq) begin
        $display("%0t: frequency_hz expected %0d actual %0d", $time, want.freq, got.freq);
        errors++;
      end
      if (got.high_t !== want.high_t) begin
        $display("%0t: high_ticks expected %0d actual %0d", $time, want.high_t, got.high_t);
        errors++;
      end
      if (got.low_t !== want.low_t) begin
        $display("%0t: low_ticks expected %0d actual %0d", $time, want.low_t, got.low_t);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [pdfm_pkg::IN_TDATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [pdfm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [pdfm_pkg::TICK_W-1:0] cfg_data;

  duty_freq_tracker tracker = new();
  bit sender_gaps;
  bit sink_stalls;
  bit level_now;
  int quiet_cycles = 0;
  int stall_left = 0;

  bit directed_levels[21] = '{1, 0, 1, 1, 1, 0, 0, 0, 0, 0, 1,
                              0, 1, 0, 0, 1, 1, 0, 1, 1, 0};

  pwm_duty_frequency_meter dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int gap_len(int longest);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 8);
    return $urandom_range(longest / 2, longest);
  endfunction

  function automatic int run_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 92) return $urandom_range(7, 40);
    return $urandom_range(100, 400);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) tracker.note_sample(s_axis_tdata[0]);
      if (m_axis_tvalid && m_axis_tready) tracker.check_reading(m_axis_tdata);
      if (cfg_valid && cfg_ready) tracker.set_rate(cfg_data);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (sink_stalls && $urandom_range(0, 99) < 15) stall_left = gap_len(80);
      end
    end
  end

  task automatic send_level(input bit lvl);
    int gap;
    gap = 0;
    if (sender_gaps && $urandom_range(0, 99) < 30) gap = gap_len(60);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(pdfm_pkg::IN_TDATA_W-1){1'b0}}, lvl};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  task automatic settle_outputs();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rate(input logic [pdfm_pkg::TICK_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int items, input bit pause_mid);
    int sent;
    int n;
    bit paused;
    sent = 0;
    paused = 1'b0;
    while (sent < items) begin
      n = run_len();
      if (n > items - sent) n = items - sent;
      level_now = ~level_now;
      repeat (n) send_level(level_now);
      sent += n;
      if (pause_mid && !paused && sent >= items / 2) begin
        settle_outputs();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    sender_gaps = 1'b0;
    sink_stalls = 1'b1;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // A first sample that is high starts the meter, then pulses of varied lengths, some one sample long.
    foreach (directed_levels[i]) send_level(directed_levels[i]);
    level_now = directed_levels[20];
    settle_outputs();

    sender_gaps = 1'b1;
    write_rate({pdfm_pkg::TICK_W{1'b1}});
    random_phase(PHASE_ITEMS, 1'b0);
    settle_outputs();

    write_rate(pdfm_pkg::TICK_W'(1));
    sink_stalls = $urandom_range(0, 3) != 0;
    random_phase(PHASE_ITEMS, 1'b0);
    settle_outputs();

    write_rate(pdfm_pkg::TICK_W'($urandom_range(1, {pdfm_pkg::TICK_W{1'b1}})));
    sender_gaps = $urandom_range(0, 3) != 0;
    sink_stalls = 1'b1;
    random_phase(PHASE_ITEMS, 1'b1);
    settle_outputs();

    write_rate(pdfm_pkg::TICK_W'($urandom_range(1, 100000)));
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    random_phase(PHASE_ITEMS, 1'b0);
    settle_outputs();

    if (tracker.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, tracker.pending());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
